### rtl/halfway_quaternion_from_vectors_assert.svh
// Assertion macros for the halfway quaternion block.
// The enclosing module supplies clk and rst_n.
`ifndef HALFWAY_QUATERNION_FROM_VECTORS_ASSERT_SVH
`define HALFWAY_QUATERNION_FROM_VECTORS_ASSERT_SVH
`ifndef SYNTHESIS
`define HQFV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HQFV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HQFV_ASSERT_IMP(label, ante, cons, msg)
`define HQFV_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### rtl/hqfv_pkg.sv
`default_nettype none
package hqfv_pkg;

    localparam int DEF_FRAC_BITS = 14;
    // extra fraction bits carried by the vector length
    localparam int EXTRA_BITS = 14;
    localparam int CW = 16;                   // component width
    localparam int SW = CW + 1;               // component sum width
    localparam int SQW = 2 * SW;              // square width
    localparam int NW = SQW + 1;              // squared length width
    localparam int RADW = 64;                 // radicand width
    localparam int ROOTW = RADW / 2;          // root width
    localparam int SQRT_LAT = ROOTW;          // one root bit per stage

    typedef struct packed {
        logic signed [CW-1:0] src_x;
        logic signed [CW-1:0] src_y;
        logic signed [CW-1:0] src_z;
        logic signed [CW-1:0] dst_x;
        logic signed [CW-1:0] dst_y;
        logic signed [CW-1:0] dst_z;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] quat_w;
        logic signed [CW-1:0] quat_x;
        logic signed [CW-1:0] quat_y;
        logic signed [CW-1:0] quat_z;
        logic                 degenerate;
    } out_item_t;

endpackage
`default_nettype wire

### rtl/halfway_quaternion_from_vectors.sv
`default_nettype none
// Channel   Handshake          Payload     Notes
// in        start / busy       operands    taken when start high and busy low
// out       done (strobe)      result      valid for one cycle, cannot be held off
//
// Fully pipelined: one item per cycle, busy never rises.
// Pipeline stages: three for sum, squares and length, 32 stages of the
// bit-per-stage square root, FRAC_BITS + 3 stages of the restoring divider,
// then products, sums, output.
// Reset clears all valid bits; data registers are not reset.
module halfway_quaternion_from_vectors
    import hqfv_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  operands,
    output logic      done,
    output out_item_t result
);

`include "halfway_quaternion_from_vectors_assert.svh"

    localparam int QW = FRAC_BITS + 2;
    localparam int DIV_LAT = QW + 1;
    localparam int PW = CW + QW + 1;
    localparam int SUMW = PW + 2;
    localparam logic [SUMW-1:0] LIM_POS = SUMW'(2 ** (CW - 1) - 1);
    localparam logic [SUMW-1:0] LIM_NEG = SUMW'(2 ** (CW - 1));

    logic accept;
    logic signed [CW-1:0] in_a [0:2];
    logic signed [CW-1:0] in_b [0:2];

    assign busy = 1'b0;
    assign accept = start && !busy;
    assign in_a[0] = operands.src_x;
    assign in_a[1] = operands.src_y;
    assign in_a[2] = operands.src_z;
    assign in_b[0] = operands.dst_x;
    assign in_b[1] = operands.dst_y;
    assign in_b[2] = operands.dst_z;

    // stage registers
    logic                 a_vld_reg, b_vld_reg, c_vld_reg;
    logic signed [CW-1:0] a_a_reg [0:2];
    logic signed [SW-1:0] a_s_reg [0:2];
    logic signed [CW-1:0] b_a_reg [0:2];
    logic signed [SW-1:0] b_s_reg [0:2];
    logic [SQW-1:0]       b_sq_reg [0:2];
    logic signed [CW-1:0] c_a_reg [0:2];
    logic signed [SW-1:0] c_s_reg [0:2];
    logic [NW-1:0]        c_n_reg;
    logic                 c_degen_reg;
    logic signed [SQW-1:0] sq_next [0:2];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            sq_next[k] = SQW'(a_s_reg[k]) * SQW'(a_s_reg[k]);
    end

    // sum, square, accumulate length
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_a_reg[k]  <= in_a[k];
            a_s_reg[k]  <= SW'(in_a[k]) + SW'(in_b[k]);
            b_a_reg[k]  <= a_a_reg[k];
            b_s_reg[k]  <= a_s_reg[k];
            b_sq_reg[k] <= unsigned'(sq_next[k]);
            c_a_reg[k]  <= b_a_reg[k];
            c_s_reg[k]  <= b_s_reg[k];
        end
        c_n_reg     <= NW'(b_sq_reg[0]) + NW'(b_sq_reg[1]) + NW'(b_sq_reg[2]);
        c_degen_reg <= (b_s_reg[0] == '0) && (b_s_reg[1] == '0) && (b_s_reg[2] == '0);
    end

    // square root of the length, with side data delayed alongside
    logic [ROOTW-1:0] root;

    hqfv_isqrt u_isqrt (
        .clk      (clk),
        .radicand (RADW'({c_n_reg, {(2 * EXTRA_BITS){1'b0}}})),
        .root     (root)
    );

    logic [SQRT_LAT-1:0]  sb1_vld_reg;
    logic [SQRT_LAT-1:0]  sb1_degen_reg;
    logic signed [CW-1:0] sb1_a_reg [0:SQRT_LAT-1][0:2];
    logic signed [SW-1:0] sb1_s_reg [0:SQRT_LAT-1][0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb1_vld_reg <= '0;
        else
            sb1_vld_reg <= {sb1_vld_reg[SQRT_LAT-2:0], c_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        sb1_degen_reg <= {sb1_degen_reg[SQRT_LAT-2:0], c_degen_reg};
        for (int k = 0; k < 3; k++)
        begin
            sb1_a_reg[0][k] <= c_a_reg[k];
            sb1_s_reg[0][k] <= c_s_reg[k];
            for (int j = 1; j < SQRT_LAT; j++)
            begin
                sb1_a_reg[j][k] <= sb1_a_reg[j-1][k];
                sb1_s_reg[j][k] <= sb1_s_reg[j-1][k];
            end
        end
    end

    // halfway vector, one divider lane per component
    logic signed [QW:0] h [0:2];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            hqfv_div #(
                .FRAC_BITS (FRAC_BITS)
            ) u_div (
                .clk (clk),
                .num (sb1_s_reg[SQRT_LAT-1][g]),
                .den (root),
                .quo (h[g])
            );
        end
    endgenerate

    logic [DIV_LAT-1:0]   sb2_vld_reg;
    logic [DIV_LAT-1:0]   sb2_degen_reg;
    logic signed [CW-1:0] sb2_a_reg [0:DIV_LAT-1][0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb2_vld_reg <= '0;
        else
            sb2_vld_reg <= {sb2_vld_reg[DIV_LAT-2:0], sb1_vld_reg[SQRT_LAT-1]};
    end

    always_ff @(posedge clk)
    begin
        sb2_degen_reg <= {sb2_degen_reg[DIV_LAT-2:0], sb1_degen_reg[SQRT_LAT-1]};
        for (int k = 0; k < 3; k++)
        begin
            sb2_a_reg[0][k] <= sb1_a_reg[SQRT_LAT-1][k];
            for (int j = 1; j < DIV_LAT; j++)
                sb2_a_reg[j][k] <= sb2_a_reg[j-1][k];
        end
    end

    // products of source and halfway components
    logic                 prod_vld_reg, prod_degen_reg;
    logic signed [PW-1:0] prod_reg [0:2][0:2];
    logic                 sum_vld_reg, sum_degen_reg;
    logic signed [SUMW-1:0] sum_reg [0:3];
    logic                 done_reg;
    out_item_t            result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= sb2_vld_reg[DIV_LAT-1];
            sum_vld_reg  <= prod_vld_reg;
            done_reg     <= sum_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_degen_reg <= sb2_degen_reg[DIV_LAT-1];
        for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++)
                prod_reg[j][k] <= PW'(sb2_a_reg[DIV_LAT-1][j]) * PW'(h[k]);
    end

    // dot and cross
    always_ff @(posedge clk)
    begin
        sum_degen_reg <= prod_degen_reg;
        sum_reg[0] <= SUMW'(prod_reg[0][0]) + SUMW'(prod_reg[1][1]) + SUMW'(prod_reg[2][2]);
        sum_reg[1] <= SUMW'(prod_reg[1][2]) - SUMW'(prod_reg[2][1]);
        sum_reg[2] <= SUMW'(prod_reg[2][0]) - SUMW'(prod_reg[0][2]);
        sum_reg[3] <= SUMW'(prod_reg[0][1]) - SUMW'(prod_reg[1][0]);
    end

    // round to nearest with ties away from zero, then saturate
    function automatic logic signed [CW-1:0] scale_sat(input logic signed [SUMW-1:0] v);
        logic            neg;
        logic [SUMW-1:0] mag;
        logic [SUMW-1:0] q;
        logic signed [CW-1:0] r;
        neg = v[SUMW-1];
        mag = neg ? SUMW'(-v) : SUMW'(v);
        q = (mag + (SUMW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (neg)
            r = (q > LIM_NEG) ? CW'(LIM_NEG) : CW'(-q);
        else
            r = (q > LIM_POS) ? CW'(LIM_POS) : CW'(q);
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (sum_degen_reg)
        begin
            result_reg.quat_w <= '0;
            result_reg.quat_x <= '0;
            result_reg.quat_y <= '0;
            result_reg.quat_z <= '0;
        end
        else
        begin
            result_reg.quat_w <= scale_sat(sum_reg[0]);
            result_reg.quat_x <= scale_sat(sum_reg[1]);
            result_reg.quat_y <= scale_sat(sum_reg[2]);
            result_reg.quat_z <= scale_sat(sum_reg[3]);
        end
        result_reg.degenerate <= sum_degen_reg;
    end

    assign done = done_reg;
    assign result = result_reg;

    `HQFV_ASSERT_IMP(a_degen_zero, done && result.degenerate, result.quat_w == '0 && result.quat_x == '0 && result.quat_y == '0 && result.quat_z == '0, "degenerate item has nonzero quaternion")
    `HQFV_ASSERT_NXT(a_sum_to_out, sum_vld_reg, done && (result.degenerate == $past(sum_degen_reg)), "summed item not delivered next cycle")
    `HQFV_ASSERT_NXT(a_div_to_prod, sb2_vld_reg[DIV_LAT-1], prod_vld_reg && (prod_degen_reg == $past(sb2_degen_reg[DIV_LAT-1])), "divider output lost its item")

endmodule
`default_nettype wire

### rtl/hqfv_isqrt.sv
`default_nettype none
module hqfv_isqrt
    import hqfv_pkg::*;
(
    input  logic             clk,
    input  logic [RADW-1:0]  radicand,
    output logic [ROOTW-1:0] root
);

    logic [RADW-1:0] rem_reg [0:ROOTW-1];
    logic [RADW-1:0] res_reg [0:ROOTW-1];

    genvar i;
    generate
        for (i = 0; i < ROOTW; i++)
        begin : g_step
            localparam logic [RADW-1:0] STEP_BIT = RADW'(1) << (2 * (ROOTW - 1 - i));
            logic [RADW-1:0] rem_in;
            logic [RADW-1:0] res_in;
            logic [RADW-1:0] trial;
            logic [RADW-1:0] rem_next;
            logic [RADW-1:0] res_next;

            if (i == 0)
            begin : g_first
                assign rem_in = radicand;
                assign res_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign res_in = res_reg[i-1];
            end

            // try one root bit, subtract when it fits
            always_comb
            begin
                trial = res_in + STEP_BIT;
                if (rem_in >= trial)
                begin
                    rem_next = rem_in - trial;
                    res_next = (res_in >> 1) + STEP_BIT;
                end
                else
                begin
                    rem_next = rem_in;
                    res_next = res_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next;
                res_reg[i] <= res_next;
            end
        end
    endgenerate

    assign root = res_reg[ROOTW-1][ROOTW-1:0];

endmodule
`default_nettype wire

### rtl/hqfv_div.sv
`default_nettype none
module hqfv_div
    import hqfv_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                       clk,
    input  logic signed [SW-1:0]       num,
    input  logic [ROOTW-1:0]           den,
    output logic signed [FRAC_BITS+2:0] quo
);

    localparam int QW = FRAC_BITS + 2;
    localparam int SHIFT = FRAC_BITS + EXTRA_BITS;
    localparam int RW = SHIFT + SW + 2;

    logic [RW-1:0]    rem_reg [0:QW-1];
    logic [QW-1:0]    q_reg   [0:QW-1];
    logic [ROOTW-1:0] den_reg [0:QW-1];
    logic             neg_reg [0:QW-1];
    logic signed [QW:0] quo_reg;

    logic [SW-1:0] mag;
    logic [RW-1:0] dividend;

    // scale magnitude and add half the divisor for rounding
    always_comb
    begin
        mag = num[SW-1] ? SW'(-num) : SW'(num);
        dividend = (RW'(mag) << SHIFT) + RW'(den >> 1);
    end

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_step
            localparam int SH = QW - 1 - i;
            logic [RW-1:0]    rem_in;
            logic [QW-1:0]    q_in;
            logic [ROOTW-1:0] den_in;
            logic             neg_in;
            logic [RW-1:0]    trial;
            logic [RW-1:0]    rem_next;
            logic             bit_next;

            if (i == 0)
            begin : g_first
                assign rem_in = dividend;
                assign q_in   = '0;
                assign den_in = den;
                assign neg_in = num[SW-1];
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign q_in   = q_reg[i-1];
                assign den_in = den_reg[i-1];
                assign neg_in = neg_reg[i-1];
            end

            // restoring step: one quotient bit
            always_comb
            begin
                trial = RW'(den_in) << SH;
                bit_next = (rem_in >= trial);
                rem_next = bit_next ? rem_in - trial : rem_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next;
                q_reg[i]   <= {q_in[QW-2:0], bit_next};
                den_reg[i] <= den_in;
                neg_reg[i] <= neg_in;
            end
        end
    endgenerate

    // restore sign
    always_ff @(posedge clk)
    begin
        if (neg_reg[QW-1])
            quo_reg <= -$signed({1'b0, q_reg[QW-1]});
        else
            quo_reg <= $signed({1'b0, q_reg[QW-1]});
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

### tb/halfway_quaternion_from_vectors_tb.sv
`timescale 1ns / 100ps
module halfway_quaternion_from_vectors_tb;
    import hqfv_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam int DRAIN_CYCLES = 41 + FRAC + 20;
    localparam int N_RANDOM = 1080;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  operands;
    logic      done;
    out_item_t result;

    out_item_t quat_q[$];
    int        n_mismatch;

    typedef struct {
        in_item_t  vec_pair;
        bit        typed;
        out_item_t quat;
    } stim_row_t;

    halfway_quaternion_from_vectors DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Bit-by-bit integer square root
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Divide, rounding to nearest with ties away from zero
    function automatic longint div_nearest(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Drop the fraction bits with rounding, then clamp to 16 bits
    function automatic logic signed [CW-1:0] drop_frac_sat(longint v);
        longint unsigned mag;
        longint unsigned q;
        longint r;
        mag = (v < 0) ? longint'(-v) : v;
        q = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
        if (q > (64'd1 << 20))
            q = 64'd1 << 20;
        r = (v < 0) ? -longint'(q) : longint'(q);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[CW-1:0];
    endfunction

    // Shortest-arc quaternion through the halfway vector
    function automatic out_item_t arc_quat(in_item_t p);
        longint a[3];
        longint s[3];
        longint h[3];
        longint unsigned n;
        longint unsigned len;
        out_item_t q;
        a[0] = p.src_x;
        a[1] = p.src_y;
        a[2] = p.src_z;
        s[0] = a[0] + longint'(p.dst_x);
        s[1] = a[1] + longint'(p.dst_y);
        s[2] = a[2] + longint'(p.dst_z);
        n = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
        q = '0;
        if (n == 0)
        begin
            q.degenerate = 1'b1;
            return q;
        end
        len = int_sqrt(n << (2 * EXTRA_BITS));
        for (int i = 0; i < 3; i++)
            h[i] = div_nearest(s[i] * (longint'(1) << (FRAC + EXTRA_BITS)), len);
        q.quat_w = drop_frac_sat(a[0] * h[0] + a[1] * h[1] + a[2] * h[2]);
        q.quat_x = drop_frac_sat(a[1] * h[2] - a[2] * h[1]);
        q.quat_y = drop_frac_sat(a[2] * h[0] - a[0] * h[2]);
        q.quat_z = drop_frac_sat(a[0] * h[1] - a[1] * h[0]);
        return q;
    endfunction

    function automatic in_item_t mk_pair(int sx, int sy, int sz, int dx, int dy, int dz);
        in_item_t p;
        p.src_x = sx[CW-1:0];
        p.src_y = sy[CW-1:0];
        p.src_z = sz[CW-1:0];
        p.dst_x = dx[CW-1:0];
        p.dst_y = dy[CW-1:0];
        p.dst_z = dz[CW-1:0];
        return p;
    endfunction

    function automatic logic signed [CW-1:0] rand_comp();
        int v;
        v = $urandom_range(32768);
        return CW'(v - 16384);
    endfunction

    // Present one item and hold it until taken; queue its expectation
    task automatic send_item(in_item_t p, out_item_t q);
        start <= 1'b1;
        operands <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        quat_q.push_back(q);
    endtask

    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(99) < 12)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (quat_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                out_item_t e;
                e = quat_q.pop_front();
                if (result !== e)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p, got %p", e, result);
                end
            end
        end
    end

    initial
    begin
        #(4 * 200000);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        out_item_t z;
        out_item_t unit_x;
        in_item_t  p;
        int        k;
        int        wait_cnt;

        n_mismatch = 0;
        start = 1'b0;
        operands = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        z = '0;
        z.degenerate = 1'b1;
        unit_x = '0;
        unit_x.quat_w = 16'sd16384;

        // Directed rows: opposite, equal, perpendicular and near-opposite pairs, field extremes
        rows.push_back('{mk_pair(0, 0, 0, 0, 0, 0), 1, z});
        rows.push_back('{mk_pair(16384, 0, 0, -16384, 0, 0), 1, z});
        rows.push_back('{mk_pair(0, -16384, 0, 0, 16384, 0), 1, z});
        rows.push_back('{mk_pair(32767, -32767, 5, -32767, 32767, -5), 1, z});
        rows.push_back('{mk_pair(16384, 0, 0, 16384, 0, 0), 1, unit_x});
        rows.push_back('{mk_pair(16384, 0, 0, 0, 16384, 0), 0, z});
        rows.push_back('{mk_pair(0, 0, 16384, 0, 16384, 0), 0, z});
        rows.push_back('{mk_pair(0, 16384, 0, 0, 0, -16384), 0, z});
        rows.push_back('{mk_pair(16384, 0, 0, -16383, 1, 0), 0, z});
        rows.push_back('{mk_pair(16384, 0, 0, -16384, 0, 1), 0, z});
        rows.push_back('{mk_pair(-32768, -32768, -32768, -32768, -32768, -32768), 0, z});
        rows.push_back('{mk_pair(32767, 32767, 32767, 32767, 32767, 32767), 0, z});
        rows.push_back('{mk_pair(32767, -32768, 32767, -32768, 32767, -32768), 0, z});
        rows.push_back('{mk_pair(-32768, 0, 0, 32767, 0, 0), 0, z});
        rows.push_back('{mk_pair(9459, 9459, 9459, -9459, 9459, 9459), 0, z});
        rows.push_back('{mk_pair(1, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{mk_pair(-1, -1, -1, 0, 0, 0), 0, z});
        rows.push_back('{mk_pair(32767, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{mk_pair(11585, 11585, 0, 0, 11585, -11585), 0, z});
        rows.push_back('{mk_pair(-16384, 0, 0, 0, 0, 16384), 0, z});

        foreach (rows[i])
        begin
            maybe_idle(1'b1);
            send_item(rows[i].vec_pair,
                      rows[i].typed ? rows[i].quat : arc_quat(rows[i].vec_pair));
        end

        // Random pairs: mostly in range, some opposite, near-opposite, equal or raw bits
        for (int i = 0; i < N_RANDOM; i++)
        begin
            maybe_idle(i < 350 || i > 600);
            if (i == 800)
            begin
                // hold off until the pipeline drains
                start <= 1'b0;
                while (quat_q.size() != 0)
                    @(posedge clk);
            end
            k = $urandom_range(99);
            p.src_x = rand_comp();
            p.src_y = rand_comp();
            p.src_z = rand_comp();
            p.dst_x = rand_comp();
            p.dst_y = rand_comp();
            p.dst_z = rand_comp();
            if (k < 10)
            begin
                p.dst_x = -p.src_x;
                p.dst_y = -p.src_y;
                p.dst_z = -p.src_z;
            end
            else if (k < 18)
            begin
                p.dst_x = p.src_x;
                p.dst_y = p.src_y;
                p.dst_z = p.src_z;
            end
            else if (k < 25)
            begin
                p.dst_x = -p.src_x + CW'($urandom_range(2)) - 16'sd1;
                p.dst_y = -p.src_y;
                p.dst_z = -p.src_z + CW'($urandom_range(2)) - 16'sd1;
            end
            else if (k < 45)
            begin
                p = in_item_t'({$urandom, $urandom, $urandom});
            end
            send_item(p, arc_quat(p));
        end
        start <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        wait_cnt = 0;
        while (quat_q.size() != 0 && wait_cnt < 10000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_mismatch == 0 && quat_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
